/* rtl/pngu_pkg.sv */
`default_nettype none

package pngu_pkg;

  // Line store geometry and row limits.
  localparam int LINE_BYTES = 8192;
  localparam int ADDR_W     = $clog2(LINE_BYTES);
  localparam int MAX_WIDTH  = 2048;
  localparam int POS_W      = 14;

  // Configuration register indexes.
  localparam logic [1:0] REG_WIDTH  = 2'd0;
  localparam logic [1:0] REG_HEIGHT = 2'd1;
  localparam logic [1:0] REG_MODE   = 2'd2;

  // Colour modes.
  localparam logic [1:0] MODE_GRAY = 2'd0;
  localparam logic [1:0] MODE_RGB  = 2'd1;

  // Scanline filter types as coded in the stream.
  typedef enum logic [2:0] {
    FILT_NONE  = 3'd0,
    FILT_SUB   = 3'd1,
    FILT_UP    = 3'd2,
    FILT_AVG   = 3'd3,
    FILT_PAETH = 3'd4
  } filter_t;

  // One sample request on its way from the address stage to reconstruction.
  typedef struct packed {
    logic [7:0]        sample;
    logic [POS_W-1:0]  idx;
    logic [ADDR_W-1:0] addr;
    logic              in_range;
    filter_t           filter;
    logic              first;
    logic [2:0]        bpp;
    logic [1:0]        chan;
    logic              emit;
    logic              row_end;
    logic              image_end;
    logic              error;
  } s1_t;

endpackage

`default_nettype wire

/* rtl/pngu_ram.sv */
`default_nettype none

module pngu_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 256
) (
  input  wire logic                     clk,
  input  wire logic                     we,
  input  wire logic [$clog2(DEPTH)-1:0] waddr,
  input  wire logic [WIDTH-1:0]         wdata,
  input  wire logic                     re,
  input  wire logic [$clog2(DEPTH)-1:0] raddr,
  output logic      [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  // One write port and one registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    if (re) begin
      rdata <= mem[raddr];
    end
  end

endmodule

`default_nettype wire

/* rtl/pngu_predict.sv */
`default_nettype none

module pngu_predict import pngu_pkg::*; (
  input  wire filter_t     filter,
  input  wire logic [7:0]  sample,
  input  wire logic [7:0]  left,
  input  wire logic [7:0]  up,
  input  wire logic [7:0]  up_left,
  output logic      [7:0]  value
);

  logic [9:0] diff_b;
  logic [9:0] diff_a;
  logic [9:0] diff_p;
  logic [9:0] dist_a;
  logic [9:0] dist_b;
  logic [9:0] dist_c;
  logic [8:0] sum_ab;
  logic [7:0] paeth;
  logic [7:0] pred;

  // Paeth distances: p - a = b - c, p - b = a - c, p - c = a + b - 2c.
  always_comb begin
    diff_b = {2'b00, up} - {2'b00, up_left};
    diff_a = {2'b00, left} - {2'b00, up_left};
    diff_p = diff_a + diff_b;
    dist_a = diff_b[9] ? (10'd0 - diff_b) : diff_b;
    dist_b = diff_a[9] ? (10'd0 - diff_a) : diff_a;
    dist_c = diff_p[9] ? (10'd0 - diff_p) : diff_p;
    if ((dist_a <= dist_b) && (dist_a <= dist_c)) begin
      paeth = left;
    end else if (dist_b <= dist_c) begin
      paeth = up;
    end else begin
      paeth = up_left;
    end
  end

  // Predictor selection and reconstruction modulo 256.
  always_comb begin
    sum_ab = {1'b0, left} + {1'b0, up};
    unique case (filter)
      FILT_NONE:  pred = 8'd0;
      FILT_SUB:   pred = left;
      FILT_UP:    pred = up;
      FILT_AVG:   pred = sum_ab[8:1];
      FILT_PAETH: pred = paeth;
      default:    pred = 8'd0;
    endcase
    value = sample + pred;
  end

endmodule

`default_nettype wire

/* rtl/png_unfilter_to_rgb_top.sv */
// Channel  Handshake            Payload
// in       in_valid / in_stall  data_byte, start_image
// out      out_valid / out_stall red, green, blue, row_end, image_end, filter_error
// cfg      cfg_write_enable     cfg_index, cfg_data
//
// One byte is taken each cycle while in_stall is low.
// Each pixel passes the s1 register and line store read, then the output register.
// Reset is synchronous; the line store is not cleared, as the first row reads zero above.
// A stalled output holds the reconstruction stage, which in turn stalls the input.
`default_nettype none

module png_unfilter_to_rgb_top import pngu_pkg::*; (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        in_valid,
  output logic             in_stall,
  input  wire logic [7:0]  data_byte,
  input  wire logic        start_image,
  output logic             out_valid,
  input  wire logic        out_stall,
  output logic      [7:0]  red,
  output logic      [7:0]  green,
  output logic      [7:0]  blue,
  output logic             row_end,
  output logic             image_end,
  output logic             filter_error,
  input  wire logic        cfg_write_enable,
  input  wire logic [1:0]  cfg_index,
  input  wire logic [15:0] cfg_data
);

  // Configuration registers.
  logic [11:0] image_width;
  logic [15:0] image_height;
  logic [1:0]  color_mode;

  // Stream position state.
  logic [POS_W-1:0] pos, pos_next, pos_e;
  logic [15:0]      row, row_next, row_e;
  filter_t          filter, filter_next, filter_e;
  logic             first, first_next, first_e;
  logic [1:0]       chan, chan_next, chan_e;
  logic             halted, halted_next, halted_e;

  // Derived geometry.
  logic [11:0]      w_eff;
  logic [15:0]      h_eff;
  logic [2:0]       bpp;
  logic [POS_W-1:0] row_len;

  // Pipeline.
  logic       in_acc;
  logic       clr;
  logic       s1_valid;
  logic       s1_adv;
  logic       s1_fire;
  logic       s1_load;
  s1_t        s1;
  s1_t        s1_in;
  logic [POS_W-1:0] idx;
  logic [15:0]      row_inc;
  logic             done;
  logic             emit;

  // Reconstruction.
  logic [31:0] left_bytes;
  logic [31:0] upper_left_bytes;
  logic [15:0] partial_pixel;
  logic [7:0]  mem_rdata;
  logic [7:0]  nb_a, nb_b, nb_c, left_far, upper_far;
  logic [7:0]  val;
  logic        mem_we;
  logic        mem_re;
  logic [7:0]  red_next, green_next, blue_next;

  // Configuration writes.
  always_ff @(posedge clk) begin
    if (rst) begin
      image_width  <= 12'd1;
      image_height <= 16'd1;
      color_mode   <= MODE_GRAY;
    end else if (cfg_write_enable) begin
      unique case (cfg_index)
        REG_WIDTH:  image_width  <= cfg_data[11:0];
        REG_HEIGHT: image_height <= cfg_data;
        REG_MODE:   color_mode   <= cfg_data[1:0];
        default:    ;
      endcase
    end
  end

  // Clamped geometry and bytes per row.
  always_comb begin
    if (image_width == 12'd0) begin
      w_eff = 12'd1;
    end else if (image_width > 12'(MAX_WIDTH)) begin
      w_eff = 12'(MAX_WIDTH);
    end else begin
      w_eff = image_width;
    end
    h_eff = (image_height == 16'd0) ? 16'd1 : image_height;
    if (color_mode == MODE_GRAY) begin
      bpp = 3'd1;
    end else if (color_mode == MODE_RGB) begin
      bpp = 3'd3;
    end else begin
      bpp = 3'd4;
    end
    unique case (bpp)
      3'd1:    row_len = {2'b00, w_eff};
      3'd3:    row_len = {2'b00, w_eff} + {1'b0, w_eff, 1'b0};
      default: row_len = {w_eff, 2'b00};
    endcase
  end

  // Handshake: the reconstruction stage moves when the output register is free.
  assign s1_adv   = !out_valid || !out_stall;
  assign s1_fire  = s1_valid && s1_adv;
  assign in_stall = s1_valid && !s1_adv;
  assign in_acc   = in_valid && !in_stall;
  assign clr      = in_acc && start_image;

  // Address stage: byte counting, filter bytes and row bookkeeping.
  always_comb begin
    pos_e    = clr ? '0 : pos;
    row_e    = clr ? 16'd0 : row;
    filter_e = clr ? FILT_NONE : filter;
    first_e  = clr ? 1'b1 : first;
    chan_e   = clr ? 2'd0 : chan;
    halted_e = clr ? 1'b0 : halted;

    pos_next    = pos_e;
    row_next    = row_e;
    filter_next = filter_e;
    first_next  = first_e;
    chan_next   = chan_e;
    halted_next = halted_e;

    idx     = pos_e - POS_W'(1);
    row_inc = row_e + 16'd1;
    done    = (pos_e >= row_len);
    emit    = (bpp == 3'd1) || ((chan_e == 2'd2) && (bpp == 3'd3)) || (chan_e == 2'd3);

    s1_load          = 1'b0;
    s1_in.sample     = data_byte;
    s1_in.idx        = idx;
    s1_in.addr       = idx[ADDR_W-1:0];
    s1_in.in_range   = (idx < POS_W'(LINE_BYTES));
    s1_in.filter     = filter_e;
    s1_in.first      = first_e;
    s1_in.bpp        = bpp;
    s1_in.chan       = chan_e;
    s1_in.emit       = emit;
    s1_in.row_end    = done;
    s1_in.image_end  = done && (row_inc >= h_eff);
    s1_in.error      = 1'b0;

    if (in_acc && !halted_e && (row_e < h_eff)) begin
      if (pos_e == '0) begin
        if (data_byte > 8'(FILT_PAETH)) begin
          halted_next  = 1'b1;
          s1_load      = 1'b1;
          s1_in.error  = 1'b1;
        end else begin
          filter_next = filter_t'(data_byte[2:0]);
          chan_next   = 2'd0;
          pos_next    = POS_W'(1);
        end
      end else begin
        s1_load = 1'b1;
        if (emit || ({1'b0, chan_e} + 3'd1 >= bpp)) begin
          chan_next = 2'd0;
        end else begin
          chan_next = chan_e + 2'd1;
        end
        if (done) begin
          chan_next  = 2'd0;
          pos_next   = '0;
          row_next   = row_inc;
          first_next = 1'b0;
        end else begin
          pos_next = pos_e + POS_W'(1);
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      pos    <= '0;
      row    <= 16'd0;
      filter <= FILT_NONE;
      first  <= 1'b1;
      chan   <= 2'd0;
      halted <= 1'b0;
    end else begin
      pos    <= pos_next;
      row    <= row_next;
      filter <= filter_next;
      first  <= first_next;
      chan   <= chan_next;
      halted <= halted_next;
    end
  end

  // Reconstruction stage register.
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid <= 1'b0;
    end else if (s1_load) begin
      s1_valid <= 1'b1;
    end else if (s1_adv) begin
      s1_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_load) begin
      s1 <= s1_in;
    end
  end

  // Previous row: read as the byte is taken, written back as it is rebuilt.
  assign mem_re = s1_load && !s1_in.error;
  assign mem_we = s1_fire && !s1.error && s1.in_range;

  pngu_ram #(
    .WIDTH(8),
    .DEPTH(LINE_BYTES)
  ) u_line_store (
    .clk   (clk),
    .we    (mem_we),
    .waddr (s1.addr),
    .wdata (val),
    .re    (mem_re),
    .raddr (s1_in.addr),
    .rdata (mem_rdata)
  );

  // Neighbours one pixel back within the row.
  always_comb begin
    unique case (s1.bpp)
      3'd1: begin
        left_far  = left_bytes[7:0];
        upper_far = upper_left_bytes[7:0];
      end
      3'd3: begin
        left_far  = left_bytes[23:16];
        upper_far = upper_left_bytes[23:16];
      end
      default: begin
        left_far  = left_bytes[31:24];
        upper_far = upper_left_bytes[31:24];
      end
    endcase
    nb_a = (s1.idx >= POS_W'(s1.bpp)) ? left_far : 8'd0;
    nb_b = (!s1.first && s1.in_range) ? mem_rdata : 8'd0;
    nb_c = ((s1.idx >= POS_W'(s1.bpp)) && !s1.first) ? upper_far : 8'd0;
  end

  pngu_predict u_predict (
    .filter  (s1.filter),
    .sample  (s1.sample),
    .left    (nb_a),
    .up      (nb_b),
    .up_left (nb_c),
    .value   (val)
  );

  // Neighbour history and pixel assembly.
  always_ff @(posedge clk) begin
    if (s1_fire && !s1.error) begin
      left_bytes       <= {left_bytes[23:0], val};
      upper_left_bytes <= {upper_left_bytes[23:0], nb_b};
      if (s1.bpp != 3'd1) begin
        if (s1.chan == 2'd0) begin
          partial_pixel <= {8'd0, val};
        end else if (s1.chan == 2'd1) begin
          partial_pixel[15:8] <= val;
        end
      end
    end
  end

  always_comb begin
    if (s1.bpp == 3'd1) begin
      red_next   = val;
      green_next = val;
      blue_next  = val;
    end else begin
      red_next   = partial_pixel[7:0];
      green_next = partial_pixel[15:8];
      blue_next  = (s1.chan == 2'd3) ? left_bytes[7:0] : val;
    end
  end

  // Output register.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (s1_fire && (s1.error || s1.emit)) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (s1_fire && (s1.error || s1.emit)) begin
      if (s1.error) begin
        red          <= 8'd0;
        green        <= 8'd0;
        blue         <= 8'd0;
        row_end      <= 1'b0;
        image_end    <= 1'b0;
        filter_error <= 1'b1;
      end else begin
        red          <= red_next;
        green        <= green_next;
        blue         <= blue_next;
        row_end      <= s1.row_end;
        image_end    <= s1.image_end;
        filter_error <= 1'b0;
      end
    end
  end

  // The line store is never read and written at one address in the same cycle.
  assert property (@(posedge clk) disable iff (rst)
    (mem_we && mem_re) |-> (s1.addr != s1_in.addr))
    else $error("line store read and write collide");

  // An error result carries no pixel and no row marks.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && filter_error) |->
      (red == 8'd0) && (green == 8'd0) && (blue == 8'd0) && !row_end && !image_end)
    else $error("error result with pixel content");

  // The last pixel of the image is also the last of its row.
  assert property (@(posedge clk) disable iff (rst)
    (out_valid && image_end) |-> row_end)
    else $error("image end without row end");

  // Once halted, only a new image releases the block.
  assert property (@(posedge clk) disable iff (rst)
    (halted && !clr) |=> halted)
    else $error("halt released without start of image");

endmodule

`default_nettype wire

/* tb/tb_top.sv */
`timescale 1ns / 1ps

module tb_top;
  import pngu_pkg::*;

  // Colour mode codes beyond the two that the package names.
  localparam logic [1:0] MODE_RGBA     = 2'd2;
  localparam logic [1:0] MODE_RGBA_ALT = 2'd3;
  // Lowest filter byte that the block must reject.
  localparam logic [7:0] BAD_FILTER_LOW = 8'(FILT_PAETH) + 8'd1;
  localparam int SETTLE_CYCLES = 8;
  localparam int RANDOM_BYTES  = 1300;

  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic       row_end;
    logic       image_end;
    logic       error;
  } pixel_t;

  typedef struct {
    logic [7:0] value;
    logic       first;
    logic       wait_empty;
  } stream_byte_t;

  logic        clk = 1'b0;
  logic        rst = 1'b1;
  logic        in_valid = 1'b0;
  logic        in_stall;
  logic [7:0]  data_byte = 8'h00;
  logic        start_image = 1'b0;
  logic        out_valid;
  logic        out_stall = 1'b0;
  logic [7:0]  red;
  logic [7:0]  green;
  logic [7:0]  blue;
  logic        row_end;
  logic        image_end;
  logic        filter_error;
  logic        cfg_write_enable = 1'b0;
  logic [1:0]  cfg_index = REG_WIDTH;
  logic [15:0] cfg_data = 16'h0000;

  png_unfilter_to_rgb_top dut (
    .clk              (clk),
    .rst              (rst),
    .in_valid         (in_valid),
    .in_stall         (in_stall),
    .data_byte        (data_byte),
    .start_image      (start_image),
    .out_valid        (out_valid),
    .out_stall        (out_stall),
    .red              (red),
    .green            (green),
    .blue             (blue),
    .row_end          (row_end),
    .image_end        (image_end),
    .filter_error     (filter_error),
    .cfg_write_enable (cfg_write_enable),
    .cfg_index        (cfg_index),
    .cfg_data         (cfg_data)
  );

  always #4 clk = ~clk;

  // Requests waiting to be offered, and pixels the unfilter predicts.
  stream_byte_t stream_bytes[$];
  pixel_t       expected_pixels[$];

  int bytes_queued = 0;
  int bytes_taken  = 0;
  int n_fail       = 0;
  int n_pixels     = 0;
  int n_row_ends   = 0;
  int n_image_ends = 0;
  int n_errors     = 0;
  int phase_no     = 0;
  int send_idle_pct  = 0;
  int recv_stall_pct = 0;

  // Predictor state: configuration and the reconstruction context.
  logic [11:0] cfg_width  = 12'd1;
  logic [15:0] cfg_height = 16'd1;
  logic [1:0]  cfg_mode   = MODE_GRAY;
  logic [7:0]  above_row [0:LINE_BYTES-1];
  logic [31:0] left_hist;
  logic [31:0] upper_hist;
  logic [13:0] byte_pos;
  logic [15:0] row_cnt;
  filter_t     cur_filter;
  logic        top_row;
  logic [1:0]  chan;
  logic [15:0] part_pixel;
  logic        stopped;

  task automatic restart_image();
    left_hist  = '0;
    upper_hist = '0;
    byte_pos   = '0;
    row_cnt    = '0;
    cur_filter = FILT_NONE;
    top_row    = 1'b1;
    chan       = '0;
    part_pixel = '0;
    stopped    = 1'b0;
  endtask

  function automatic int paeth_choose(input int a, input int b, input int c);
    int p, pa, pb, pc;
    p  = a + b - c;
    pa = (p > a) ? p - a : a - p;
    pb = (p > b) ? p - b : b - p;
    pc = (p > c) ? p - c : c - p;
    if (pa <= pb && pa <= pc) return a;
    else if (pb <= pc) return b;
    return c;
  endfunction

  // Reconstructs one stream byte and queues the pixel it completes, if any.
  task automatic unfilter_byte(input logic [7:0] d, input logic st);
    int w, h, bpp, row_len, i, a, b, c, pred, sh;
    logic [7:0] val;
    logic done, emit;
    pixel_t px;
    if (st) restart_image();
    w = (cfg_width == 0) ? 1 : ((cfg_width > MAX_WIDTH) ? MAX_WIDTH : int'(cfg_width));
    h = (cfg_height == 0) ? 1 : int'(cfg_height);
    bpp = (cfg_mode == MODE_GRAY) ? 1 : ((cfg_mode == MODE_RGB) ? 3 : 4);
    row_len = w * bpp;
    px = '0;
    if (stopped || row_cnt >= h) return;

    // Filter byte at the head of each row.
    if (byte_pos == 0) begin
      if (d > 8'(FILT_PAETH)) begin
        stopped = 1'b1;
        px.error = 1'b1;
        expected_pixels.push_back(px);
        return;
      end
      cur_filter = filter_t'(d[2:0]);
      left_hist  = '0;
      upper_hist = '0;
      chan       = '0;
      byte_pos   = 14'd1;
      return;
    end

    // Neighbours: left, above and above-left, the upper ones zero in the first row.
    i  = int'(byte_pos) - 1;
    sh = 8 * (bpp - 1);
    a = (i >= bpp) ? int'((left_hist >> sh) & 32'hFF) : 0;
    b = (!top_row && i < LINE_BYTES) ? int'(above_row[i]) : 0;
    c = (i >= bpp && !top_row) ? int'((upper_hist >> sh) & 32'hFF) : 0;
    case (cur_filter)
      FILT_SUB:   pred = a;
      FILT_UP:    pred = b;
      FILT_AVG:   pred = (a + b) >> 1;
      FILT_PAETH: pred = paeth_choose(a, b, c);
      default:    pred = 0;
    endcase
    val = 8'(int'(d) + pred);
    if (i < LINE_BYTES) above_row[i] = val;
    left_hist  = {left_hist[23:0], val};
    upper_hist = {upper_hist[23:0], 8'(b)};

    // Gather channels into a pixel; alpha is dropped.
    done = (i + 1 >= row_len);
    emit = 1'b0;
    if (bpp == 1) begin
      emit = 1'b1;
      px.red = val;
      px.green = val;
      px.blue = val;
    end else if (chan == 0) begin
      part_pixel = {8'h00, val};
    end else if (chan == 1) begin
      part_pixel[15:8] = val;
    end else if (chan == 2) begin
      px.red   = part_pixel[7:0];
      px.green = part_pixel[15:8];
      px.blue  = val;
      if (bpp == 3) emit = 1'b1;
    end else begin
      emit     = 1'b1;
      px.red   = part_pixel[7:0];
      px.green = part_pixel[15:8];
      px.blue  = left_hist[15:8];
    end
    if (emit || int'(chan) + 1 >= bpp) chan = '0;
    else chan = chan + 2'd1;

    if (done) begin
      chan     = '0;
      byte_pos = '0;
      row_cnt  = row_cnt + 16'd1;
      top_row  = 1'b0;
    end else begin
      byte_pos = byte_pos + 14'd1;
    end
    if (!emit) return;
    px.row_end   = done;
    px.image_end = done && (row_cnt >= h);
    expected_pixels.push_back(px);
  endtask

  // Driver: offers queued requests, holding each until it is taken.
  always @(posedge clk) begin
    if (rst) begin
      in_valid <= 1'b0;
    end else begin
      if (in_valid && !in_stall) begin
        unfilter_byte(data_byte, start_image);
        bytes_taken++;
      end
      if (!in_valid || !in_stall) begin
        if (stream_bytes.size() != 0 &&
            (!stream_bytes[0].wait_empty || (!in_valid && expected_pixels.size() == 0)) &&
            $urandom_range(99) >= send_idle_pct) begin
          in_valid    <= 1'b1;
          data_byte   <= stream_bytes[0].value;
          start_image <= stream_bytes[0].first;
          void'(stream_bytes.pop_front());
        end else begin
          in_valid    <= 1'b0;
          data_byte   <= 8'($urandom);
          start_image <= 1'($urandom);
        end
      end
    end
  end

  // Monitor: compares each pixel taken with the oldest prediction.
  always @(posedge clk) begin : pixel_check
    pixel_t want, got;
    if (rst) begin
      out_stall <= 1'b0;
    end else begin
      if (out_valid && !out_stall) begin
        got = {red, green, blue, row_end, image_end, filter_error};
        if (expected_pixels.size() == 0) begin
          n_fail++;
          $display("%0t: pixel with none expected: %02h %02h %02h re=%0b ie=%0b err=%0b",
                   $time, got.red, got.green, got.blue, got.row_end,
                   got.image_end, got.error);
        end else begin
          want = expected_pixels.pop_front();
          n_pixels++;
          n_row_ends   += want.row_end;
          n_image_ends += want.image_end;
          n_errors     += want.error;
          if (got !== want) begin
            n_fail++;
            $display("%0t: pixel mismatch, expected %02h %02h %02h re=%0b ie=%0b err=%0b",
                     $time, want.red, want.green, want.blue, want.row_end,
                     want.image_end, want.error);
            $display("    got %02h %02h %02h re=%0b ie=%0b err=%0b",
                     got.red, got.green, got.blue, got.row_end, got.image_end, got.error);
          end
        end
      end
      out_stall <= ($urandom_range(99) < recv_stall_pct);
    end
  end

  task automatic push_byte(input logic [7:0] value, input logic first);
    stream_byte_t sb;
    sb.value = value;
    sb.first = first;
    sb.wait_empty = 1'b0;
    stream_bytes.push_back(sb);
    bytes_queued++;
  endtask

  // Waits until every request is taken and every pixel is out, then lets the pipe settle.
  task automatic wait_quiet();
    while (!(bytes_taken == bytes_queued && expected_pixels.size() == 0)) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [1:0] idx, input logic [15:0] val);
    @(posedge clk);
    cfg_write_enable <= 1'b1;
    cfg_index        <= idx;
    cfg_data         <= val;
    case (idx)
      REG_WIDTH:  cfg_width  = val[11:0];
      REG_HEIGHT: cfg_height = val;
      REG_MODE:   cfg_mode   = val[1:0];
      default: ;
    endcase
    @(posedge clk);
    cfg_write_enable <= 1'b0;
  endtask

  // Starts a phase once the block is quiet: new traffic pattern and configuration.
  task automatic begin_phase(input int width, input int height, input logic [1:0] mode);
    wait_quiet();
    case (phase_no % 4)
      0: begin send_idle_pct = 0;  recv_stall_pct = 0;  end
      1: begin send_idle_pct = 61; recv_stall_pct = 0;  end
      2: begin send_idle_pct = 0;  recv_stall_pct = 61; end
      default: begin send_idle_pct = 37; recv_stall_pct = 37; end
    endcase
    phase_no++;
    write_reg(REG_WIDTH, 16'(width));
    write_reg(REG_HEIGHT, 16'(height));
    write_reg(REG_MODE, 16'(mode));
  endtask

  // Queues one image with random content: mostly whole, sometimes cut short,
  // sometimes broken by a bad filter byte, at times followed by bytes to ignore.
  task automatic queue_random_image(input int w, input int h, input int bpp,
                                    input bit faults, input bit hold_first,
                                    inout int counted);
    stream_byte_t img[$];
    stream_byte_t sb;
    int rows, r, k, kind, pos, junk;
    rows = (h > 6) ? $urandom_range(3, 1) : h;
    sb.wait_empty = 1'b0;
    for (r = 0; r < rows; r++) begin
      sb.value = 8'($urandom_range(int'(FILT_PAETH), int'(FILT_NONE)));
      sb.first = (r == 0);
      img.push_back(sb);
      sb.first = 1'b0;
      for (k = 0; k < w * bpp; k++) begin
        sb.value = 8'($urandom);
        img.push_back(sb);
      end
    end
    kind = faults ? $urandom_range(99) : 99;
    junk = 0;
    if (kind < 8) begin
      pos = $urandom_range(rows - 1, 0) * (1 + w * bpp);
      img[pos].value = 8'($urandom_range(255, int'(BAD_FILTER_LOW)));
      while (img.size() > pos + 1) void'(img.pop_back());
      junk = $urandom_range(3, 0);
    end else if (kind < 18 && img.size() > 2) begin
      pos = $urandom_range(img.size() - 1, 1);
      while (img.size() > pos) void'(img.pop_back());
    end else if (kind < 40 && rows == h) begin
      junk = $urandom_range(3, 1);
    end
    img[0].wait_empty = hold_first;
    counted += img.size();
    foreach (img[j]) begin
      stream_bytes.push_back(img[j]);
      bytes_queued++;
    end
    repeat (junk) push_byte(8'($urandom), 1'b0);
  endtask

  task automatic run_phase(input int width, input int height, input logic [1:0] mode,
                           input int budget, inout int total);
    int w, h, bpp, got, n_img;
    begin_phase(width, height, mode);
    w = (width == 0) ? 1 : ((width > MAX_WIDTH) ? MAX_WIDTH : width);
    h = (height == 0) ? 1 : height;
    bpp = (mode == MODE_GRAY) ? 1 : ((mode == MODE_RGB) ? 3 : 4);
    got = 0;
    n_img = 0;
    while (got < budget) begin
      queue_random_image(w, h, bpp, (w * bpp * h < 1000),
                         (n_img == 1) || ($urandom_range(9) == 0), got);
      n_img++;
    end
    total += got;
  endtask

  initial begin : stimulus
    int random_total, extreme_total, w;
    random_total = 0;
    extreme_total = 0;
    restart_image();
    repeat (7) @(posedge clk);
    rst <= 1'b0;

    // Directed: each filter, sample extremes, a finished image, bad filter bytes.
    begin_phase(2, 2, MODE_GRAY);
    push_byte(8'(FILT_NONE), 1'b1);
    push_byte(8'h00, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(8'(FILT_PAETH), 1'b0);
    push_byte(8'h80, 1'b0);
    push_byte(8'h7F, 1'b0);
    push_byte(8'h55, 1'b0);
    push_byte(8'(FILT_SUB), 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'h01, 1'b0);
    push_byte(8'(FILT_UP), 1'b0);
    push_byte(8'h10, 1'b0);
    push_byte(8'hF0, 1'b0);
    push_byte(8'(FILT_AVG), 1'b1);
    push_byte(8'hFF, 1'b0);
    push_byte(8'hFF, 1'b0);
    push_byte(BAD_FILTER_LOW, 1'b0);
    push_byte(8'h12, 1'b0);
    push_byte(8'hFF, 1'b1);
    push_byte(8'(FILT_PAETH), 1'b1);
    push_byte(8'h01, 1'b0);
    push_byte(8'h02, 1'b0);
    push_byte(8'(FILT_AVG), 1'b0);
    push_byte(8'h03, 1'b0);
    push_byte(8'h04, 1'b0);

    // Directed: the row is shortened part way through a pixel.
    begin_phase(4, 3, MODE_RGBA);
    push_byte(8'(FILT_NONE), 1'b1);
    repeat (6) push_byte(8'($urandom), 1'b0);
    wait_quiet();
    write_reg(REG_WIDTH, 16'd1);
    push_byte(8'($urandom), 1'b0);
    push_byte(8'(FILT_UP), 1'b0);
    repeat (4) push_byte(8'($urandom), 1'b0);
    push_byte(8'(FILT_PAETH), 1'b0);
    repeat (4) push_byte(8'($urandom), 1'b0);

    // Configuration extremes: zero sizes, the fourth mode code, the tallest image.
    run_phase(0, 0, MODE_RGBA_ALT, 100, extreme_total);
    run_phase(3, 65535, MODE_RGB, 100, extreme_total);

    // Random phases, mostly small images.
    while (random_total < RANDOM_BYTES) begin
      case ($urandom_range(9))
        0, 1:    w = $urandom_range(40, 7);
        2:       w = 0;
        default: w = $urandom_range(6, 1);
      endcase
      run_phase(w, $urandom_range(5, 0), 2'($urandom_range(3, 0)), 120, random_total);
    end

    wait_quiet();
    $display("Sent %0d stream bytes (%0d in random images) over %0d phases of traffic.",
             bytes_taken, random_total, phase_no);
    $display("Checked %0d pixels: %0d row ends, %0d image ends, %0d bad filter reports.",
             n_pixels, n_row_ends, n_image_ends, n_errors);
    if (n_fail == 0 && expected_pixels.size() == 0) begin
      $display("simulation ok");
    end else begin
      $display("simulation failed");
    end
    $finish;
  end

  // Guard against a hung handshake.
  initial begin
    #8ms;
    $display("simulation failed");
    $finish;
  end

endmodule

/* sim.f */
rtl/pngu_pkg.sv
rtl/pngu_ram.sv
rtl/pngu_predict.sv
rtl/png_unfilter_to_rgb_top.sv
tb/tb_top.sv
